// ===== sv/kdlq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlq_pkg
// shared types and constants of the keyed doubly linked queue unit
// ----------------------------------------------------------------------------
package kdlq_pkg;

	localparam int KDLQ_POOL_DEPTH  = 16;
	localparam int KDLQ_MAX_RESULTS = 16;
	localparam int KDLQ_FIFO_DEPTH  = 4;

	localparam int REQ_W  = 4;
	localparam int KEY_W  = 37;
	localparam int ACCT_W = 31;
	localparam int AGY_W  = 16;
	localparam int SVC_W  = 2;
	localparam int ST_W   = 3;
	localparam int QC_W   = 5;
	localparam int TOT_W  = 16;
	localparam int FL_W   = 2;

	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 200;

	// request codes on the input kind field
	localparam logic [REQ_W-1:0] REQ_INS_HEAD  = 4'd0;
	localparam logic [REQ_W-1:0] REQ_INS_TAIL  = 4'd1;
	localparam logic [REQ_W-1:0] REQ_INS_AFTER = 4'd2;
	localparam logic [REQ_W-1:0] REQ_RM_HEAD   = 4'd3;
	localparam logic [REQ_W-1:0] REQ_RM_TAIL   = 4'd4;
	localparam logic [REQ_W-1:0] REQ_RM_KEY    = 4'd5;
	localparam logic [REQ_W-1:0] REQ_FIND      = 4'd6;
	localparam logic [REQ_W-1:0] REQ_NEIGHBOUR = 4'd7;
	localparam logic [REQ_W-1:0] REQ_WALK_FWD  = 4'd8;
	localparam logic [REQ_W-1:0] REQ_WALK_BACK = 4'd9;
	localparam logic [REQ_W-1:0] REQ_WALK_TYPE = 4'd10;

	typedef enum logic [3:0] {
		OP_INS_HEAD,
		OP_INS_TAIL,
		OP_INS_AFTER,
		OP_RM_HEAD,
		OP_RM_TAIL,
		OP_RM_KEY,
		OP_FIND,
		OP_NEIGHBOUR,
		OP_WALK_FWD,
		OP_WALK_BACK,
		OP_WALK_TYPE,
		OP_NONE
	} op_t;

	typedef enum logic [ST_W-1:0] {
		STAT_OK,
		STAT_FULL,
		STAT_EMPTY,
		STAT_DUP,
		STAT_NOT_FOUND
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_SRCH_GO,
		S_SRCH,
		S_RD_GO,
		S_RD,
		S_UNLINK,
		S_INS1,
		S_INS2,
		S_NB_P,
		S_NB_PG,
		S_NB_N,
		S_NB_NG,
		S_WALK_GO,
		S_WALK,
		S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		PH_ANCHOR,
		PH_DUP,
		PH_RMKEY,
		PH_FIND,
		PH_NB
	} phase_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [KEY_W-1:0]  anchor;
		logic [ACCT_W-1:0] acct;
		logic [AGY_W-1:0]  agy;
		logic [SVC_W-1:0]  svc;
	} req_t;

endpackage

// ===== sv/keyed_doubly_linked_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_doubly_linked_queue_unit
// keyed queue of linked slots with insert, remove, lookup and walk requests
// ----------------------------------------------------------------------------
// Requests enter a four-item queue and are executed one at a time by a list
// engine that reads one slot per cycle from its slot memories, unless a walk
// waits on the output register. Find, neighbour and remove by key search the
// list for the key, insert at head or tail searches it for a duplicate key
// and insert-after searches first for the anchor and then for a duplicate.
// Walks emit up to sixteen result items, the last one marked with tlast.
// Result items leave through an output register, so a walk keeps going while
// the previous item waits on m_tready, until it has another matching entry
// to hand on.
// ----------------------------------------------------------------------------
module keyed_doubly_linked_queue_unit #(
	parameter int POOL_DEPTH = kdlq_pkg::KDLQ_POOL_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// entry_key, anchor_key, account_number, agency_code, service_kind
	input  logic [kdlq_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type
	input  logic [kdlq_pkg::REQ_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_key, out_account, out_agency, out_service, prev_key, following_key,
	// neighbour_flags, queue_count, served_total, added_total
	output logic [kdlq_pkg::OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [kdlq_pkg::ST_W-1:0]       m_tuser,
	output logic                            m_tlast
);
	import kdlq_pkg::*;

	logic req_valid;
	req_t req;
	logic req_pop;

	kdlq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.req_valid(req_valid),
		.req      (req),
		.req_pop  (req_pop)
	);

	kdlq_back #(
		.POOL_DEPTH(POOL_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.req_pop  (req_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== sv/kdlq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlq_front
// accepts request items, decodes the request kind and queues them
// ----------------------------------------------------------------------------
module kdlq_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// entry_key, anchor_key, account_number, agency_code, service_kind
	input  logic [kdlq_pkg::IN_DATA_W-1:0] s_tdata,
	// req_type
	input  logic [kdlq_pkg::REQ_W-1:0]     s_tuser,
	output logic                          req_valid,
	output kdlq_pkg::req_t                req,
	input  logic                          req_pop
);
	import kdlq_pkg::*;

	localparam int PW = $clog2(KDLQ_FIFO_DEPTH);

	req_t            fifo_mem [KDLQ_FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     fill_q;
	req_t            in_item;
	logic            push;
	logic            pop;

	always_comb begin
		in_item.key    = s_tdata[36:0];
		in_item.anchor = s_tdata[73:37];
		in_item.acct   = s_tdata[104:74];
		in_item.agy    = s_tdata[120:105];
		in_item.svc    = s_tdata[122:121];
		case (s_tuser)
			REQ_INS_HEAD:  in_item.op = OP_INS_HEAD;
			REQ_INS_TAIL:  in_item.op = OP_INS_TAIL;
			REQ_INS_AFTER: in_item.op = OP_INS_AFTER;
			REQ_RM_HEAD:   in_item.op = OP_RM_HEAD;
			REQ_RM_TAIL:   in_item.op = OP_RM_TAIL;
			REQ_RM_KEY:    in_item.op = OP_RM_KEY;
			REQ_FIND:      in_item.op = OP_FIND;
			REQ_NEIGHBOUR: in_item.op = OP_NEIGHBOUR;
			REQ_WALK_FWD:  in_item.op = OP_WALK_FWD;
			REQ_WALK_BACK: in_item.op = OP_WALK_BACK;
			REQ_WALK_TYPE: in_item.op = OP_WALK_TYPE;
			default:       in_item.op = OP_NONE;
		endcase
	end

	assign s_tready  = (fill_q != (PW+1)'(KDLQ_FIFO_DEPTH));
	assign push      = s_tvalid & s_tready;
	assign req_valid = (fill_q != '0);
	assign pop       = req_pop & req_valid;
	assign req       = fifo_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/kdlq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlq_back
// list engine: slot memories, link walker, updates and result register
// ----------------------------------------------------------------------------
module kdlq_back #(
	parameter int POOL_DEPTH = kdlq_pkg::KDLQ_POOL_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  kdlq_pkg::req_t                  req,
	output logic                            req_pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_key, out_account, out_agency, out_service, prev_key, following_key,
	// neighbour_flags, queue_count, served_total, added_total
	output logic [kdlq_pkg::OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [kdlq_pkg::ST_W-1:0]       m_tuser,
	output logic                            m_tlast
);
	import kdlq_pkg::*;

	localparam int IW = $clog2(POOL_DEPTH);
	localparam int LW = IW + 1;
	localparam int CW = $clog2(POOL_DEPTH + 1);
	localparam int NW = $clog2(KDLQ_MAX_RESULTS + 1);
	localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};

	// slot memories
	logic [KEY_W-1:0]  key_mem  [POOL_DEPTH];
	logic [ACCT_W-1:0] acct_mem [POOL_DEPTH];
	logic [AGY_W-1:0]  agy_mem  [POOL_DEPTH];
	logic [SVC_W-1:0]  svc_mem  [POOL_DEPTH];
	logic [LW-1:0]     prev_mem [POOL_DEPTH];
	logic [LW-1:0]     next_mem [POOL_DEPTH];

	logic [KEY_W-1:0]  rd_key_q;
	logic [ACCT_W-1:0] rd_acct_q;
	logic [AGY_W-1:0]  rd_agy_q;
	logic [SVC_W-1:0]  rd_svc_q;
	logic [LW-1:0]     rd_prev_q;
	logic [LW-1:0]     rd_next_q;

	logic [IW-1:0] rd_addr;
	logic          ent_we;
	logic [IW-1:0] ent_wa;
	logic          prev_we;
	logic [IW-1:0] prev_wa;
	logic [LW-1:0] prev_wd;
	logic          next_we;
	logic [IW-1:0] next_wa;
	logic [LW-1:0] next_wd;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	req_t   rq_q, rq_d;

	logic [LW-1:0]       cur_q, cur_d;
	logic [CW-1:0]       steps_q, steps_d;
	logic [NW-1:0]       nres_q, nres_d;
	status_t             st_q, st_d;
	logic [KEY_W-1:0]    ekey_q, ekey_d;
	logic [ACCT_W-1:0]   eacct_q, eacct_d;
	logic [AGY_W-1:0]    eagy_q, eagy_d;
	logic [SVC_W-1:0]    esvc_q, esvc_d;
	logic [LW-1:0]       eprev_q, eprev_d;
	logic [LW-1:0]       enext_q, enext_d;
	logic [KEY_W-1:0]    pk_q, pk_d;
	logic [KEY_W-1:0]    fk_q, fk_d;
	logic [FL_W-1:0]     fl_q, fl_d;
	logic                pend_q, pend_d;
	logic [LW-1:0]       slot_q, slot_d;
	logic [LW-1:0]       anc_q, anc_d;
	logic [LW-1:0]       ancnx_q, ancnx_d;
	logic [LW-1:0]       head_q, head_d;
	logic [LW-1:0]       tail_q, tail_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [TOT_W-1:0]    srv_q, srv_d;
	logic [TOT_W-1:0]    add_q, add_d;
	logic [POOL_DEPTH-1:0] used_q, used_d;

	logic                ov_q, ov_d;
	status_t             ost_q, ost_d;
	logic [KEY_W-1:0]    okey_q, okey_d;
	logic [ACCT_W-1:0]   oacct_q, oacct_d;
	logic [AGY_W-1:0]    oagy_q, oagy_d;
	logic [SVC_W-1:0]    osvc_q, osvc_d;
	logic [KEY_W-1:0]    opk_q, opk_d;
	logic [KEY_W-1:0]    ofk_q, ofk_d;
	logic [FL_W-1:0]     ofl_q, ofl_d;
	logic [QC_W-1:0]     oqc_q, oqc_d;
	logic [TOT_W-1:0]    osrv_q, osrv_d;
	logic [TOT_W-1:0]    oadd_q, oadd_d;
	logic                olast_q, olast_d;

	logic             can_emit;
	logic             is_empty;
	logic             srch_hit;
	logic             srch_miss;
	logic [KEY_W-1:0] target;
	logic [LW-1:0]    free_idx;
	logic             w_match;
	logic [LW-1:0]    w_next;
	logic [NW-1:0]    w_nres;
	logic             w_end;

	function automatic logic [LW-1:0] lowest_free(input logic [POOL_DEPTH-1:0] u);
		logic [LW-1:0] r;
		r = NIL;
		for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
			if (!u[i]) begin
				r = LW'(i);
			end
		end
		return r;
	endfunction

	assign can_emit = !ov_q || m_tready;
	assign is_empty = (cnt_q == '0) || head_q[IW];
	assign target   = (phase_q == PH_ANCHOR) ? rq_q.anchor : rq_q.key;
	assign free_idx = lowest_free(used_q);
	assign w_match  = (rq_q.op != OP_WALK_TYPE) || (rd_svc_q == rq_q.svc);
	assign w_next   = (rq_q.op == OP_WALK_BACK) ? rd_prev_q : rd_next_q;
	assign w_nres   = nres_q + NW'(w_match);
	assign w_end    = w_next[IW] || (steps_q == CW'(POOL_DEPTH - 1)) ||
	                  (w_nres >= NW'(KDLQ_MAX_RESULTS));

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		rq_d    = rq_q;
		cur_d   = cur_q;
		steps_d = steps_q;
		nres_d  = nres_q;
		st_d    = st_q;
		ekey_d  = ekey_q;
		eacct_d = eacct_q;
		eagy_d  = eagy_q;
		esvc_d  = esvc_q;
		eprev_d = eprev_q;
		enext_d = enext_q;
		pk_d    = pk_q;
		fk_d    = fk_q;
		fl_d    = fl_q;
		pend_d  = pend_q;
		slot_d  = slot_q;
		anc_d   = anc_q;
		ancnx_d = ancnx_q;
		head_d  = head_q;
		tail_d  = tail_q;
		cnt_d   = cnt_q;
		srv_d   = srv_q;
		add_d   = add_q;
		used_d  = used_q;
		ov_d    = ov_q && !m_tready;
		ost_d   = ost_q;
		okey_d  = okey_q;
		oacct_d = oacct_q;
		oagy_d  = oagy_q;
		osvc_d  = osvc_q;
		opk_d   = opk_q;
		ofk_d   = ofk_q;
		ofl_d   = ofl_q;
		oqc_d   = oqc_q;
		osrv_d  = osrv_q;
		oadd_d  = oadd_q;
		olast_d = olast_q;
		req_pop = 1'b0;
		rd_addr = cur_q[IW-1:0];
		ent_we  = 1'b0;
		ent_wa  = slot_q[IW-1:0];
		prev_we = 1'b0;
		prev_wa = slot_q[IW-1:0];
		prev_wd = NIL;
		next_we = 1'b0;
		next_wa = slot_q[IW-1:0];
		next_wd = NIL;
		srch_hit  = 1'b0;
		srch_miss = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_pop = 1'b1;
					rq_d    = req;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				ekey_d  = '0;
				eacct_d = '0;
				eagy_d  = '0;
				esvc_d  = '0;
				pk_d    = '0;
				fk_d    = '0;
				fl_d    = '0;
				pend_d  = 1'b0;
				nres_d  = '0;
				steps_d = '0;
				cur_d   = head_q;
				st_d    = STAT_OK;
				case (rq_q.op)
					OP_INS_HEAD, OP_INS_TAIL, OP_INS_AFTER: begin
						if (cnt_q >= CW'(POOL_DEPTH)) begin
							st_d    = STAT_FULL;
							state_d = S_EMIT;
						end else begin
							phase_d = (rq_q.op == OP_INS_AFTER) ? PH_ANCHOR : PH_DUP;
							state_d = S_SRCH_GO;
						end
					end
					OP_RM_HEAD, OP_RM_TAIL: begin
						if (is_empty) begin
							st_d    = STAT_EMPTY;
							state_d = S_EMIT;
						end else begin
							slot_d  = (rq_q.op == OP_RM_HEAD) ? head_q : tail_q;
							state_d = S_RD_GO;
						end
					end
					OP_RM_KEY, OP_FIND: begin
						if (is_empty) begin
							st_d    = STAT_EMPTY;
							state_d = S_EMIT;
						end else begin
							phase_d = (rq_q.op == OP_RM_KEY) ? PH_RMKEY : PH_FIND;
							state_d = S_SRCH_GO;
						end
					end
					OP_NEIGHBOUR: begin
						phase_d = PH_NB;
						state_d = S_SRCH_GO;
					end
					OP_WALK_FWD, OP_WALK_BACK, OP_WALK_TYPE: begin
						if (is_empty) begin
							st_d    = STAT_EMPTY;
							state_d = S_EMIT;
						end else begin
							cur_d   = (rq_q.op == OP_WALK_BACK) ? tail_q : head_q;
							state_d = S_WALK_GO;
						end
					end
					default: begin
						state_d = S_EMIT;
					end
				endcase
			end
			S_SRCH_GO: begin
				if (cur_q[IW]) begin
					srch_miss = 1'b1;
				end else begin
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				if (used_q[cur_q[IW-1:0]] && rd_key_q == target) begin
					srch_hit = 1'b1;
				end else if (rd_next_q[IW] || steps_q == CW'(POOL_DEPTH - 1)) begin
					srch_miss = 1'b1;
				end else begin
					cur_d   = rd_next_q;
					steps_d = steps_q + 1'b1;
					rd_addr = rd_next_q[IW-1:0];
				end
			end
			S_RD_GO: begin
				rd_addr = slot_q[IW-1:0];
				state_d = S_RD;
			end
			S_RD: begin
				ekey_d  = rd_key_q;
				eacct_d = rd_acct_q;
				eagy_d  = rd_agy_q;
				esvc_d  = rd_svc_q;
				eprev_d = rd_prev_q;
				enext_d = rd_next_q;
				state_d = S_UNLINK;
			end
			S_UNLINK: begin
				if (!enext_q[IW]) begin
					prev_we = 1'b1;
					prev_wa = enext_q[IW-1:0];
					prev_wd = eprev_q;
				end else begin
					tail_d = eprev_q;
				end
				if (!eprev_q[IW]) begin
					next_we = 1'b1;
					next_wa = eprev_q[IW-1:0];
					next_wd = enext_q;
				end else begin
					head_d = enext_q;
				end
				used_d[slot_q[IW-1:0]] = 1'b0;
				if (cnt_q != '0) begin
					cnt_d = cnt_q - 1'b1;
				end
				if (srv_q != '1) begin
					srv_d = srv_q + 1'b1;
				end
				st_d    = STAT_OK;
				state_d = S_EMIT;
			end
			S_INS1: begin
				ent_we  = 1'b1;
				prev_we = 1'b1;
				next_we = 1'b1;
				used_d[slot_q[IW-1:0]] = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (add_q != '1) begin
					add_d = add_q + 1'b1;
				end
				ekey_d  = rq_q.key;
				eacct_d = rq_q.acct;
				eagy_d  = rq_q.agy;
				esvc_d  = rq_q.svc;
				st_d    = STAT_OK;
				state_d = S_INS2;
				if (head_q[IW]) begin
					head_d  = slot_q;
					tail_d  = slot_q;
					state_d = S_EMIT;
				end else begin
					case (rq_q.op)
						OP_INS_HEAD: begin
							next_wd = head_q;
							anc_d   = head_q;
							head_d  = slot_q;
						end
						OP_INS_TAIL: begin
							prev_wd = tail_q;
							anc_d   = tail_q;
							tail_d  = slot_q;
						end
						default: begin
							prev_wd = anc_q;
							next_wd = ancnx_q;
							if (ancnx_q[IW]) begin
								tail_d = slot_q;
							end
						end
					endcase
				end
			end
			S_INS2: begin
				case (rq_q.op)
					OP_INS_HEAD: begin
						prev_we = 1'b1;
						prev_wa = anc_q[IW-1:0];
						prev_wd = slot_q;
					end
					OP_INS_TAIL: begin
						next_we = 1'b1;
						next_wa = anc_q[IW-1:0];
						next_wd = slot_q;
					end
					default: begin
						next_we = 1'b1;
						next_wa = anc_q[IW-1:0];
						next_wd = slot_q;
						if (!ancnx_q[IW]) begin
							prev_we = 1'b1;
							prev_wa = ancnx_q[IW-1:0];
							prev_wd = slot_q;
						end
					end
				endcase
				state_d = S_EMIT;
			end
			S_NB_P: begin
				if (eprev_q[IW]) begin
					state_d = S_NB_N;
				end else begin
					rd_addr = eprev_q[IW-1:0];
					state_d = S_NB_PG;
				end
			end
			S_NB_PG: begin
				pk_d    = rd_key_q;
				fl_d[0] = 1'b1;
				state_d = S_NB_N;
			end
			S_NB_N: begin
				if (enext_q[IW]) begin
					state_d = S_EMIT;
				end else begin
					rd_addr = enext_q[IW-1:0];
					state_d = S_NB_NG;
				end
			end
			S_NB_NG: begin
				fk_d    = rd_key_q;
				fl_d[1] = 1'b1;
				state_d = S_EMIT;
			end
			S_WALK_GO: begin
				state_d = S_WALK;
			end
			S_WALK: begin
				if (!(w_match && pend_q && !can_emit)) begin
					if (w_match) begin
						if (pend_q) begin
							ov_d    = 1'b1;
							ost_d   = STAT_OK;
							okey_d  = ekey_q;
							oacct_d = eacct_q;
							oagy_d  = eagy_q;
							osvc_d  = esvc_q;
							opk_d   = '0;
							ofk_d   = '0;
							ofl_d   = '0;
							oqc_d   = QC_W'(cnt_q);
							osrv_d  = srv_q;
							oadd_d  = add_q;
							olast_d = 1'b0;
						end
						ekey_d  = rd_key_q;
						eacct_d = rd_acct_q;
						eagy_d  = rd_agy_q;
						esvc_d  = rd_svc_q;
						pend_d  = 1'b1;
					end
					nres_d  = w_nres;
					steps_d = steps_q + 1'b1;
					if (w_end) begin
						st_d    = (w_match || pend_q) ? STAT_OK : STAT_NOT_FOUND;
						state_d = S_EMIT;
					end else begin
						cur_d   = w_next;
						rd_addr = w_next[IW-1:0];
					end
				end
			end
			S_EMIT: begin
				if (can_emit) begin
					ov_d    = 1'b1;
					ost_d   = st_q;
					okey_d  = (st_q == STAT_OK) ? ekey_q : '0;
					oacct_d = (st_q == STAT_OK) ? eacct_q : '0;
					oagy_d  = (st_q == STAT_OK) ? eagy_q : '0;
					osvc_d  = (st_q == STAT_OK) ? esvc_q : '0;
					opk_d   = pk_q;
					ofk_d   = fk_q;
					ofl_d   = fl_q;
					oqc_d   = QC_W'(cnt_q);
					osrv_d  = srv_q;
					oadd_d  = add_q;
					olast_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (srch_hit || srch_miss) begin
			case (phase_q)
				PH_ANCHOR: begin
					if (srch_miss) begin
						st_d    = STAT_NOT_FOUND;
						state_d = S_EMIT;
					end else begin
						anc_d   = cur_q;
						ancnx_d = rd_next_q;
						phase_d = PH_DUP;
						cur_d   = head_q;
						steps_d = '0;
						state_d = S_SRCH_GO;
					end
				end
				PH_DUP: begin
					if (srch_hit) begin
						st_d    = STAT_DUP;
						state_d = S_EMIT;
					end else if (free_idx[IW]) begin
						st_d    = STAT_FULL;
						state_d = S_EMIT;
					end else begin
						slot_d  = free_idx;
						state_d = S_INS1;
					end
				end
				default: begin
					if (srch_miss) begin
						st_d    = STAT_NOT_FOUND;
						state_d = S_EMIT;
					end else begin
						ekey_d  = rd_key_q;
						eacct_d = rd_acct_q;
						eagy_d  = rd_agy_q;
						esvc_d  = rd_svc_q;
						eprev_d = rd_prev_q;
						enext_d = rd_next_q;
						slot_d  = cur_q;
						st_d    = STAT_OK;
						if (phase_q == PH_RMKEY) begin
							state_d = S_UNLINK;
						end else if (phase_q == PH_NB) begin
							state_d = S_NB_P;
						end else begin
							state_d = S_EMIT;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			key_mem[ent_wa]  <= rq_q.key;
			acct_mem[ent_wa] <= rq_q.acct;
			agy_mem[ent_wa]  <= rq_q.agy;
			svc_mem[ent_wa]  <= rq_q.svc;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		rd_key_q  <= key_mem[rd_addr];
		rd_acct_q <= acct_mem[rd_addr];
		rd_agy_q  <= agy_mem[rd_addr];
		rd_svc_q  <= svc_mem[rd_addr];
		rd_prev_q <= prev_mem[rd_addr];
		rd_next_q <= next_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		rq_q    <= rq_d;
		cur_q   <= cur_d;
		steps_q <= steps_d;
		nres_q  <= nres_d;
		st_q    <= st_d;
		ekey_q  <= ekey_d;
		eacct_q <= eacct_d;
		eagy_q  <= eagy_d;
		esvc_q  <= esvc_d;
		eprev_q <= eprev_d;
		enext_q <= enext_d;
		pk_q    <= pk_d;
		fk_q    <= fk_d;
		fl_q    <= fl_d;
		pend_q  <= pend_d;
		slot_q  <= slot_d;
		anc_q   <= anc_d;
		ancnx_q <= ancnx_d;
		ost_q   <= ost_d;
		okey_q  <= okey_d;
		oacct_q <= oacct_d;
		oagy_q  <= oagy_d;
		osvc_q  <= osvc_d;
		opk_q   <= opk_d;
		ofk_q   <= ofk_d;
		ofl_q   <= ofl_d;
		oqc_q   <= oqc_d;
		osrv_q  <= osrv_d;
		oadd_q  <= oadd_d;
		olast_q <= olast_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_DUP;
			head_q  <= NIL;
			tail_q  <= NIL;
			cnt_q   <= '0;
			srv_q   <= '0;
			add_q   <= '0;
			used_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			cnt_q   <= cnt_d;
			srv_q   <= srv_d;
			add_q   <= add_d;
			used_q  <= used_d;
			ov_q    <= ov_d;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tuser  = ost_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {1'b0, oadd_q, osrv_q, oqc_q, ofl_q, ofk_q, opk_q,
	                   osvc_q, oagy_q, oacct_q, okey_q};

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(POOL_DEPTH))
		else $error("entry count above pool depth");

	a_cnt_used: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(cnt_q))
		else $error("entry count differs from used slots");

	a_head_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		head_q[IW] == (cnt_q == '0))
		else $error("head pointer and entry count disagree");

	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q[IW] == tail_q[IW])
		else $error("head and tail null state disagree");

endmodule

// ===== tb/sv/keyed_doubly_linked_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_doubly_linked_queue_unit_tb
// self-checking bench for the keyed doubly linked queue unit
// ----------------------------------------------------------------------------
// Drives directed and random list requests into the stream input. A model of
// the slot pool runs alongside and predicts every result item. Each result is
// checked field by field against the oldest prediction. Both sides of the
// stream stall at random, and one long output stall fills the unit up.
// ----------------------------------------------------------------------------
module keyed_doubly_linked_queue_unit_tb;
	import kdlq_pkg::*;

	localparam int DEPTH = KDLQ_POOL_DEPTH;
	localparam int NIL = -1;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		status_t           st;
		logic [KEY_W-1:0]  key;
		logic [ACCT_W-1:0] acct;
		logic [AGY_W-1:0]  agy;
		logic [SVC_W-1:0]  svc;
		logic [KEY_W-1:0]  pk;
		logic [KEY_W-1:0]  fk;
		logic [FL_W-1:0]   fl;
		logic [QC_W-1:0]   qc;
		logic [TOT_W-1:0]  served;
		logic [TOT_W-1:0]  added;
		logic              last;
	} result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [REQ_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [ST_W-1:0] m_tuser;
	logic m_tlast;

	keyed_doubly_linked_queue_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// pool model
	logic [KEY_W-1:0]  slot_key [DEPTH];
	logic [ACCT_W-1:0] slot_acct [DEPTH];
	logic [AGY_W-1:0]  slot_agy [DEPTH];
	logic [SVC_W-1:0]  slot_svc [DEPTH];
	int                slot_prev [DEPTH];
	int                slot_next [DEPTH];
	bit                slot_busy [DEPTH];
	int                head_slot;
	int                tail_slot;
	int                entries;
	logic [TOT_W-1:0]  served_cnt;
	logic [TOT_W-1:0]  added_cnt;

	result_t pending_results[$];
	logic [KEY_W-1:0] key_set[24];
	int errors;
	int idle_mode;
	int quiet_cycles = 0;
	bit hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int search_key(logic [KEY_W-1:0] k);
		int cur;
		cur = head_slot;
		for (int i = 0; i < DEPTH && cur != NIL; i++) begin
			if (slot_busy[cur] && slot_key[cur] == k)
				return cur;
			cur = slot_next[cur];
		end
		return NIL;
	endfunction

	function automatic result_t make_result(status_t st, int s, logic [KEY_W-1:0] pk,
			logic [KEY_W-1:0] fk, logic [FL_W-1:0] fl, logic last);
		result_t r;
		r = '{st: st, key: '0, acct: '0, agy: '0, svc: '0, pk: pk, fk: fk, fl: fl,
			qc: entries[QC_W-1:0], served: served_cnt, added: added_cnt, last: last};
		if (s != NIL) begin
			r.key = slot_key[s];
			r.acct = slot_acct[s];
			r.agy = slot_agy[s];
			r.svc = slot_svc[s];
		end
		return r;
	endfunction

	task automatic predict_request(logic [REQ_W-1:0] rq, logic [KEY_W-1:0] k,
			logic [KEY_W-1:0] anc, logic [ACCT_W-1:0] acct, logic [AGY_W-1:0] agy,
			logic [SVC_W-1:0] svc);
		int s;
		int a;
		int p;
		int q;
		int cur;
		int n;
		logic [KEY_W-1:0] pk;
		logic [KEY_W-1:0] fk;
		logic [FL_W-1:0] fl;
		case (rq)
			REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_AFTER: begin
				if (entries >= DEPTH) begin
					pending_results.push_back(make_result(STAT_FULL, NIL, '0, '0, '0, 1'b1));
					return;
				end
				a = NIL;
				if (rq == REQ_INS_AFTER) begin
					a = search_key(anc);
					if (a == NIL) begin
						pending_results.push_back(make_result(STAT_NOT_FOUND, NIL, '0, '0, '0,
							1'b1));
						return;
					end
				end
				if (search_key(k) != NIL) begin
					pending_results.push_back(make_result(STAT_DUP, NIL, '0, '0, '0, 1'b1));
					return;
				end
				s = 0;
				while (slot_busy[s])
					s++;
				slot_key[s] = k;
				slot_acct[s] = acct;
				slot_agy[s] = agy;
				slot_svc[s] = svc;
				slot_busy[s] = 1'b1;
				if (head_slot == NIL) begin
					slot_prev[s] = NIL;
					slot_next[s] = NIL;
					head_slot = s;
					tail_slot = s;
				end else if (rq == REQ_INS_HEAD) begin
					slot_prev[s] = NIL;
					slot_next[s] = head_slot;
					slot_prev[head_slot] = s;
					head_slot = s;
				end else if (rq == REQ_INS_TAIL) begin
					slot_prev[s] = tail_slot;
					slot_next[s] = NIL;
					slot_next[tail_slot] = s;
					tail_slot = s;
				end else begin
					slot_prev[s] = a;
					slot_next[s] = slot_next[a];
					if (slot_next[a] != NIL)
						slot_prev[slot_next[a]] = s;
					else
						tail_slot = s;
					slot_next[a] = s;
				end
				entries++;
				if (added_cnt != '1)
					added_cnt++;
				pending_results.push_back(make_result(STAT_OK, s, '0, '0, '0, 1'b1));
			end
			REQ_RM_HEAD, REQ_RM_TAIL, REQ_RM_KEY: begin
				if (entries == 0) begin
					pending_results.push_back(make_result(STAT_EMPTY, NIL, '0, '0, '0, 1'b1));
					return;
				end
				s = (rq == REQ_RM_HEAD) ? head_slot :
					(rq == REQ_RM_TAIL) ? tail_slot : search_key(k);
				if (s == NIL) begin
					pending_results.push_back(make_result(STAT_NOT_FOUND, NIL, '0, '0, '0,
						1'b1));
					return;
				end
				p = slot_prev[s];
				q = slot_next[s];
				if (q != NIL) slot_prev[q] = p; else tail_slot = p;
				if (p != NIL) slot_next[p] = q; else head_slot = q;
				slot_busy[s] = 1'b0;
				entries--;
				if (served_cnt != '1)
					served_cnt++;
				pending_results.push_back(make_result(STAT_OK, s, '0, '0, '0, 1'b1));
			end
			REQ_FIND: begin
				if (entries == 0) begin
					pending_results.push_back(make_result(STAT_EMPTY, NIL, '0, '0, '0, 1'b1));
					return;
				end
				s = search_key(k);
				pending_results.push_back(make_result(s == NIL ? STAT_NOT_FOUND : STAT_OK,
					s, '0, '0, '0, 1'b1));
			end
			REQ_NEIGHBOUR: begin
				s = search_key(k);
				if (s == NIL) begin
					pending_results.push_back(make_result(STAT_NOT_FOUND, NIL, '0, '0, '0,
						1'b1));
					return;
				end
				pk = '0;
				fk = '0;
				fl = '0;
				if (slot_prev[s] != NIL) begin
					pk = slot_key[slot_prev[s]];
					fl[0] = 1'b1;
				end
				if (slot_next[s] != NIL) begin
					fk = slot_key[slot_next[s]];
					fl[1] = 1'b1;
				end
				pending_results.push_back(make_result(STAT_OK, s, pk, fk, fl, 1'b1));
			end
			REQ_WALK_FWD, REQ_WALK_BACK, REQ_WALK_TYPE: begin
				if (entries == 0) begin
					pending_results.push_back(make_result(STAT_EMPTY, NIL, '0, '0, '0, 1'b1));
					return;
				end
				cur = (rq == REQ_WALK_BACK) ? tail_slot : head_slot;
				n = 0;
				for (int i = 0; i < DEPTH && cur != NIL && n < KDLQ_MAX_RESULTS; i++) begin
					if (rq != REQ_WALK_TYPE || slot_svc[cur] == svc) begin
						pending_results.push_back(make_result(STAT_OK, cur, '0, '0, '0, 1'b0));
						n++;
					end
					cur = (rq == REQ_WALK_BACK) ? slot_prev[cur] : slot_next[cur];
				end
				if (n == 0)
					pending_results.push_back(make_result(STAT_NOT_FOUND, NIL, '0, '0, '0,
						1'b1));
				else
					pending_results[pending_results.size()-1].last = 1'b1;
			end
			default: pending_results.push_back(make_result(STAT_OK, NIL, '0, '0, '0, 1'b1));
		endcase
	endtask

	task automatic send_item(logic [REQ_W-1:0] rq, logic [KEY_W-1:0] k,
			logic [KEY_W-1:0] anc, logic [ACCT_W-1:0] acct, logic [AGY_W-1:0] agy,
			logic [SVC_W-1:0] svc);
		int pct;
		pct = (idle_mode == 0) ? 24 : (idle_mode == 1) ? 54 : 0;
		if ($urandom_range(99) < pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tdata <= {5'd0, svc, agy, acct, anc, k};
		s_tuser <= rq;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_request(rq, k, anc, acct, agy, svc);
	endtask

	task automatic send_idle();
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(9) == 0)
			return KEY_W'({$urandom, $urandom});
		return key_set[$urandom_range(23)];
	endfunction

	// request type fields: empty list on every request code but insert at head and tail, then fill, overflow and rules
	task automatic test_directed();
		logic [REQ_W-1:0] rq;
		for (int r = 0; r < 16; r++) begin
			rq = REQ_W'(r);
			if (rq != REQ_INS_HEAD && rq != REQ_INS_TAIL)
				send_item(rq, key_set[0], key_set[1], '0, '0, '0);
		end
		send_item(REQ_INS_AFTER, key_set[0], key_set[1], '1, '1, 2'd3);
		send_item(REQ_INS_HEAD, '1, '0, '1, '1, 2'd3);
		send_item(REQ_INS_TAIL, '0, '0, '0, '0, 2'd0);
		send_item(REQ_INS_TAIL, '0, '0, 31'd5, 16'd5, 2'd1);
		send_item(REQ_INS_AFTER, key_set[2], '1, 31'h2AAAAAAA, 16'h5555, 2'd2);
		send_item(REQ_INS_AFTER, key_set[3], 37'd7, 31'd1, 16'd1, 2'd1);
		for (int i = 4; i < 18; i++)
			send_item(REQ_INS_TAIL, key_set[i], '0, ACCT_W'($urandom), AGY_W'($urandom),
				SVC_W'($urandom_range(3)));
		send_item(REQ_NEIGHBOUR, key_set[2], '0, '0, '0, '0);
		send_item(REQ_NEIGHBOUR, '1, '0, '0, '0, '0);
		send_item(REQ_WALK_FWD, '0, '0, '0, '0, '0);
		send_item(REQ_WALK_BACK, '0, '0, '0, '0, '0);
		send_item(REQ_WALK_TYPE, '0, '0, '0, '0, 2'd3);
		send_item(REQ_RM_KEY, 37'd99, '0, '0, '0, '0);
		send_item(REQ_RM_KEY, key_set[2], '0, '0, '0, '0);
		send_item(REQ_RM_HEAD, '0, '0, '0, '0, '0);
		send_item(REQ_RM_TAIL, '0, '0, '0, '0, '0);
		send_item(REQ_FIND, key_set[5], '0, '0, '0, '0);
		send_item(REQ_INS_HEAD, key_set[5], '0, '0, '0, '0);
	endtask

	task automatic test_random(int count);
		int w;
		logic [REQ_W-1:0] rq;
		for (int i = 0; i < count; i++) begin
			w = $urandom_range(99);
			if (w < 40) rq = REQ_W'($urandom_range(REQ_INS_AFTER, REQ_INS_HEAD));
			else if (w < 62) rq = REQ_W'($urandom_range(REQ_RM_KEY, REQ_RM_HEAD));
			else if (w < 78) rq = REQ_W'($urandom_range(REQ_NEIGHBOUR, REQ_FIND));
			else if (w < 95) rq = REQ_W'($urandom_range(REQ_WALK_TYPE, REQ_WALK_FWD));
			else rq = REQ_W'($urandom_range(15, 11));
			send_item(rq, pick_key(), pick_key(), ACCT_W'($urandom), AGY_W'($urandom),
				SVC_W'($urandom_range(3)));
		end
	endtask

	// output held off while walks keep arriving
	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int i = 0; i < 20; i++)
			send_item(REQ_WALK_FWD, '0, '0, '0, '0, '0);
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			result_t got;
			result_t want;
			got = '{st: status_t'(m_tuser), key: m_tdata[36:0], acct: m_tdata[67:37],
				agy: m_tdata[83:68], svc: m_tdata[85:84], pk: m_tdata[122:86],
				fk: m_tdata[159:123], fl: m_tdata[161:160], qc: m_tdata[166:162],
				served: m_tdata[182:167], added: m_tdata[198:183], last: m_tlast};
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result item, status %0d key %0h", $time,
					m_tuser, got.key);
			end else begin
				want = pending_results.pop_front();
				if (got.st != want.st) begin
					errors++;
					$display("%0t: status exp %0d got %0d", $time, want.st, got.st);
				end
				if (got.key != want.key) begin
					errors++;
					$display("%0t: out_key exp %0h got %0h", $time, want.key, got.key);
				end
				if (got.acct != want.acct) begin
					errors++;
					$display("%0t: out_account exp %0h got %0h", $time, want.acct, got.acct);
				end
				if (got.agy != want.agy) begin
					errors++;
					$display("%0t: out_agency exp %0h got %0h", $time, want.agy, got.agy);
				end
				if (got.svc != want.svc) begin
					errors++;
					$display("%0t: out_service exp %0d got %0d", $time, want.svc, got.svc);
				end
				if (got.pk != want.pk) begin
					errors++;
					$display("%0t: prev_key exp %0h got %0h", $time, want.pk, got.pk);
				end
				if (got.fk != want.fk) begin
					errors++;
					$display("%0t: following_key exp %0h got %0h", $time, want.fk, got.fk);
				end
				if (got.fl != want.fl) begin
					errors++;
					$display("%0t: neighbour_flags exp %0d got %0d", $time, want.fl, got.fl);
				end
				if (got.qc != want.qc) begin
					errors++;
					$display("%0t: queue_count exp %0d got %0d", $time, want.qc, got.qc);
				end
				if (got.served != want.served) begin
					errors++;
					$display("%0t: served_total exp %0d got %0d", $time, want.served,
						got.served);
				end
				if (got.added != want.added) begin
					errors++;
					$display("%0t: added_total exp %0d got %0d", $time, want.added, got.added);
				end
				if (got.last != want.last) begin
					errors++;
					$display("%0t: last exp %0b got %0b", $time, want.last, got.last);
				end
			end
		end
	end

	// receiver side
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_mode == 0) begin
				m_tready <= ($urandom_range(99) >= 54);
			end else if (idle_mode == 1) begin
				m_tready <= ($urandom_range(99) >= 24);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("keyed_doubly_linked_queue_unit test failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_mode = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		head_slot = NIL;
		tail_slot = NIL;
		entries = 0;
		served_cnt = '0;
		added_cnt = '0;
		for (int i = 0; i < DEPTH; i++)
			slot_busy[i] = 1'b0;
		for (int i = 0; i < 24; i++)
			key_set[i] = KEY_W'({$urandom, $urandom});
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(102);
		test_backpressure();
		idle_mode = 1;
		test_random(102);
		idle_mode = 2;
		test_random(102);
		send_idle();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("keyed_doubly_linked_queue_unit test passed");
		else
			$display("keyed_doubly_linked_queue_unit test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/kdlq_pkg.sv
sv/kdlq_front.sv
sv/kdlq_back.sv
sv/keyed_doubly_linked_queue_unit.sv
tb/sv/keyed_doubly_linked_queue_unit_tb.sv
